// File: rtl/s2cd_pkg.sv
// Shared types and constants for the seconds to calendar date converter.
// No dependencies; imported by every module of the block.
package s2cd_pkg;

  // Field widths of the item ports.
  localparam int SECS_W   = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Day count since the epoch, after the century correction (at most 49711).
  localparam int DAYS_W = 16;
  // Day within a four-year cycle (0..1460) and within a year (0..365).
  localparam int CYC_DAY_W = 11;
  localparam int DOY_W     = 9;
  // Whole four-year cycles since the epoch (0..34).
  localparam int CYC_W = 6;

  // Reciprocal constants: n/60 = (n * RECIP_60) >> 37 and n/24 = (n * RECIP_24) >> 36
  // for any 32-bit n.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam int          SHIFT_60 = 37;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;
  localparam int          SHIFT_24 = 36;

  // n/1461 = (n * RECIP_CYC) >> 26 for every day count this block can see.
  localparam logic [15:0] RECIP_CYC = 16'd45934;
  localparam int          SHIFT_CYC = 26;
  localparam logic [10:0] CYCLE_DAYS = 11'd1461;

  // First day of March 2100 counted from the epoch. Year 2100 is not a leap
  // year, so days from here on are moved up by one to fit a plain
  // every-fourth-year calendar.
  localparam logic [DAYS_W-1:0] SKIP_LEAP_DAY = 16'd36584;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd2000;

  // Start of each year inside a four-year cycle; the first year is the leap year.
  localparam logic [CYC_DAY_W-1:0] YEAR1_START = 11'd366;
  localparam logic [CYC_DAY_W-1:0] YEAR2_START = 11'd731;
  localparam logic [CYC_DAY_W-1:0] YEAR3_START = 11'd1096;

  // Time of day carried alongside the date work.
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  // Day of year on which month m (0 = January) begins.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

// File: rtl/s2cd_tod_split.sv
// Time-of-day split: four pipeline stages that divide the second count by
// 60, 60 and 24 with reciprocal multiplies. Depends on s2cd_pkg.
module s2cd_tod_split (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [s2cd_pkg::SECS_W-1:0]   secs,
  output logic                          out_valid,
  input  logic                          out_ready,
  output s2cd_pkg::tod_t                tod,
  output logic [s2cd_pkg::DAYS_W-1:0]   days_adj
);
  import s2cd_pkg::*;

  // Stage registers.
  logic              v1, v2, v3, v4;
  logic [31:0]       t1;
  logic [63:0]       p1;
  logic [26:0]       q1;
  logic [58:0]       p2;
  logic [SECOND_W-1:0] sec2, sec3;
  logic [20:0]       q2;
  logic [52:0]       p3;
  logic [MINUTE_W-1:0] min3;
  tod_t              tod4;
  logic [DAYS_W-1:0] days4;

  logic rdy1, rdy2, rdy3, rdy4;

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v3 || rdy3 ? (!v2 || rdy3) : !v2;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 2 combinational: minutes count and seconds.
  logic [26:0]         q1_c;
  logic [SECOND_W-1:0] sec_c;
  logic [58:0]         p2_c;
  assign q1_c  = p1[63:SHIFT_60];
  assign sec_c = SECOND_W'(t1 - 32'(q1_c) * 32'd60);
  assign p2_c  = 59'(59'(q1_c) * 59'(RECIP_60));

  // Stage 3 combinational: hours count and minutes.
  logic [20:0]         q2_c;
  logic [MINUTE_W-1:0] min_c;
  logic [52:0]         p3_c;
  assign q2_c  = p2[57:SHIFT_60];
  assign min_c = MINUTE_W'(q1 - 27'(q2_c) * 27'd60);
  assign p3_c  = 53'(53'(q2_c) * 53'(RECIP_24));

  // Stage 4 combinational: day count, hour, and the missing 2100 leap day.
  logic [DAYS_W-1:0] days_c;
  logic [HOUR_W-1:0] hr_c;
  logic [DAYS_W-1:0] adj_c;
  assign days_c = p3[51:SHIFT_24];
  assign hr_c   = HOUR_W'(q2 - 21'(days_c) * 21'd24);
  assign adj_c  = (days_c >= SKIP_LEAP_DAY) ? days_c + 16'd1 : days_c;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1 <= secs;
      p1 <= 64'(secs) * 64'(RECIP_60);
    end
    if (rdy2) begin
      q1   <= q1_c;
      sec2 <= sec_c;
      p2   <= p2_c;
    end
    if (rdy3) begin
      q2   <= q2_c;
      sec3 <= sec2;
      min3 <= min_c;
      p3   <= p3_c;
    end
    if (rdy4) begin
      tod4.second <= sec3;
      tod4.minute <= min3;
      tod4.hour   <= hr_c;
      days4       <= adj_c;
    end
  end

  assign out_valid = v4;
  assign tod       = tod4;
  assign days_adj  = days4;

  // The split fields never leave their ranges.
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (tod4.second < 6'd60))
    else $error("second out of range");
  a_min_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (tod4.minute < 6'd60))
    else $error("minute out of range");
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (tod4.hour < 5'd24) && (days4 < 16'd49712))
    else $error("hour or day count out of range");

endmodule

// File: rtl/s2cd_date_split.sv
// Date split: three pipeline stages that turn a day count into year, month
// and day using four-year cycles and a month-start table. Depends on s2cd_pkg.
module s2cd_date_split (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [s2cd_pkg::DAYS_W-1:0]    days_adj,
  input  s2cd_pkg::tod_t                 tod,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [s2cd_pkg::YEAR_W-1:0]    year,
  output logic [s2cd_pkg::MONTH_W-1:0]   month,
  output logic [s2cd_pkg::DAY_W-1:0]     day_of_month,
  output logic [s2cd_pkg::HOUR_W-1:0]    hour,
  output logic [s2cd_pkg::MINUTE_W-1:0]  minute,
  output logic [s2cd_pkg::SECOND_W-1:0]  second
);
  import s2cd_pkg::*;

  logic              v5, v6, v7;
  logic [31:0]       p5;
  logic [DAYS_W-1:0] d5;
  tod_t              tod5, tod6;
  logic [YEAR_W-1:0] year6;
  logic [DOY_W-1:0]  doy6;
  logic              leap6;

  logic rdy5, rdy6, rdy7;
  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign in_ready = rdy5;

  // Stage 6 combinational: four-year cycle, year within it, day of year.
  logic [CYC_W-1:0]     cyc_c;
  logic [CYC_DAY_W-1:0] rem_c;
  logic [1:0]           yoff_c;
  logic [CYC_DAY_W-1:0] ystart_c;
  logic [YEAR_W-1:0]    year_c;
  logic [DOY_W-1:0]     doy_c;
  assign cyc_c = p5[31:SHIFT_CYC];
  assign rem_c = CYC_DAY_W'(d5 - 16'(cyc_c) * 16'(CYCLE_DAYS));

  always_comb begin
    if (rem_c >= YEAR3_START) begin
      yoff_c   = 2'd3;
      ystart_c = YEAR3_START;
    end else if (rem_c >= YEAR2_START) begin
      yoff_c   = 2'd2;
      ystart_c = YEAR2_START;
    end else if (rem_c >= YEAR1_START) begin
      yoff_c   = 2'd1;
      ystart_c = YEAR1_START;
    end else begin
      yoff_c   = 2'd0;
      ystart_c = '0;
    end
  end

  assign year_c = EPOCH_YEAR + YEAR_W'({cyc_c, 2'b00}) + YEAR_W'(yoff_c);
  assign doy_c  = DOY_W'(rem_c - ystart_c);

  // Stage 7 combinational: last month whose start is not after the day.
  logic [MONTH_W-1:0] mon_c;
  logic [DAY_W-1:0]   dom_c;
  always_comb begin
    mon_c = '0;
    for (int m = 1; m < 12; m++) begin
      if (doy6 >= month_start(MONTH_W'(m), leap6)) begin
        mon_c = MONTH_W'(m);
      end
    end
  end
  assign dom_c = DAY_W'(doy6 - month_start(mon_c, leap6) + 9'd1);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      d5   <= days_adj;
      p5   <= 32'(days_adj) * 32'(RECIP_CYC);
      tod5 <= tod;
    end
    if (rdy6) begin
      year6 <= year_c;
      doy6  <= doy_c;
      leap6 <= (yoff_c == 2'd0);
      tod6  <= tod5;
    end
    if (rdy7) begin
      year         <= year6;
      month        <= mon_c + 4'd1;
      day_of_month <= dom_c;
      hour         <= tod6.hour;
      minute       <= tod6.minute;
      second       <= tod6.second;
    end
  end

  assign out_valid = v7;

  // Date fields stay within the calendar.
  a_doy_range: assert property (@(posedge clk) disable iff (rst)
    v6 |-> (leap6 ? (doy6 < 9'd366) : (doy6 < 9'd365)))
    else $error("day of year out of range");
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    v7 |-> (month >= 4'd1) && (month <= 4'd12))
    else $error("month out of range");
  a_day_range: assert property (@(posedge clk) disable iff (rst)
    v7 |-> (day_of_month >= 5'd1) && (year <= 12'd2136))
    else $error("day or year out of range");

endmodule

// File: rtl/seconds_to_calendar_date_unit.sv
// Top level of the seconds to calendar date converter.
// Depends on s2cd_pkg, s2cd_tod_split and s2cd_date_split.
//
// Converts an unsigned 32-bit count of seconds since 2000-01-01 00:00:00 into
// Gregorian year, month, day, hour, minute and second. The block is a
// seven-stage pipeline: four stages divide by 60, 60 and 24 with reciprocal
// multiplies, three stages resolve the year through four-year cycles and the
// month through a table of month starts. It takes one item every cycle unless
// a stall on the result side holds the pipeline; each stage does one multiply
// or one short compare-and-subtract. Each stage holds its item under a stall,
// so empty stages still fill while the result side waits.
module seconds_to_calendar_date_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [s2cd_pkg::SECS_W-1:0]    seconds_since_epoch,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [s2cd_pkg::YEAR_W-1:0]    year,
  output logic [s2cd_pkg::MONTH_W-1:0]   month,
  output logic [s2cd_pkg::DAY_W-1:0]     day_of_month,
  output logic [s2cd_pkg::HOUR_W-1:0]    hour,
  output logic [s2cd_pkg::MINUTE_W-1:0]  minute,
  output logic [s2cd_pkg::SECOND_W-1:0]  second
);
  import s2cd_pkg::*;

  logic              tod_ready;
  logic              mid_valid;
  logic              mid_ready;
  tod_t              mid_tod;
  logic [DAYS_W-1:0] mid_days;

  // Handshake polarity at the ports.
  assign req_stall = !tod_ready;

  s2cd_tod_split u_tod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (tod_ready),
    .secs      (seconds_since_epoch),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .tod       (mid_tod),
    .days_adj  (mid_days)
  );

  s2cd_date_split u_date (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .days_adj     (mid_days),
    .tod          (mid_tod),
    .out_valid    (rsp_valid),
    .out_ready    (!rsp_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

endmodule
